>>> src/ffrrc_pkg.sv
// shared types and constants of the fifo fill resampling ratio control
package ffrrc_pkg;

    localparam int STEP_W = 6;
    localparam int SPEED_W = 29;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 29'h1FFF_FFFF;

    typedef enum logic [2:0] {
        ACT_NO_DEVICE = 3'd0,
        ACT_FLUSHED   = 3'd1,
        ACT_PRIMING   = 3'd2,
        ACT_SCRATCH   = 3'd3,
        ACT_UNDERRUN  = 3'd4,
        ACT_PLAY      = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_TGT,
        ST_EVAL,
        ST_SMOOTH,
        ST_RATIO,
        ST_RDIV,
        ST_ADJMUL,
        ST_ADJSTART,
        ST_ADJDIV,
        ST_NEED,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

>>> src/fifo_fill_resample_ratio_control.sv
// top level: fifo fill driven resampling ratio control with apb registers
// One request per output block. A request without a device (dest_rate or
// output_channels zero) goes straight to the done state, and o_valid rises once
// the output register is free. Any other request runs five passes of the shared
// bit-serial divider, one quotient bit a cycle: the base ratio (43), the latency
// target (21+FRACTION_BITS), the smoothing step (14+FRACTION_BITS), the fill
// error ratio (24, skipped when the error is at least the larger of the target
// and one sample) and the speed trim (30); a request that stays priming ends
// after the target pass. The next request is accepted once the result has moved
// to the output register, even while it waits there.
module fifo_fill_resample_ratio_control
    import ffrrc_pkg::*;
#(
    parameter int FIFO_DEPTH    = 8192,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_restart,
    input  logic [13:0] i_fifo_fill,
    input  logic [12:0] i_block_samples,
    input  logic [6:0]  i_output_channels,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [13:0] o_discard_count,
    output logic [14:0] o_read_count,
    output logic [28:0] o_speed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F  = FRACTION_BITS;
    localparam int SW = 14 + F;
    localparam int TW = 19 + F;
    localparam int RW = TW + 1;
    localparam int DW = (21 + F > 43) ? 21 + F : 43;
    localparam int PW = 54;

    t_state       r_state, n_state;
    logic [18:0]  r_src, r_dst;
    logic [12:0]  r_dblk;
    logic [14:0]  r_scr;
    logic         r_pending, n_pending, r_priming, n_priming;
    logic [SW-1:0] r_smooth, n_smooth;
    logic         r_restart, n_restart;
    logic [13:0]  r_ready, n_ready, r_disc, n_disc;
    logic [12:0]  r_samples, n_samples;
    logic [28:0]  r_base, n_base, r_speed, n_speed;
    logic [TW-1:0] r_target, n_target;
    logic         r_dneg, n_dneg, r_neg, n_neg;
    logic [24:0]  r_ratio, n_ratio;
    logic [PW-1:0] r_prod;
    t_action      r_res_act, n_res_act;
    logic [13:0]  r_res_disc, n_res_disc;
    logic [14:0]  r_res_read, n_res_read;
    logic [28:0]  r_res_speed, n_res_speed;
    logic         r_out_valid;
    logic [2:0]   r_o_act;
    logic [13:0]  r_o_disc;
    logic [14:0]  r_o_read;
    logic [28:0]  r_o_speed;
    logic         load_out;

    t_div_req      div_req;
    logic [RW-1:0] div_init, div_dsor, div_rem;
    logic [DW-1:0] div_dvd, div_quot;
    logic          div_fin;

    logic [28:0]  mul_a;
    logic [24:0]  mul_b;

    ffrrc_div #(.DW(DW), .RW(RW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_init_rem (div_init),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsor),
        .o_fin      (div_fin),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // apb registers
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            2'd0: prdata = {13'b0, r_src};
            2'd1: prdata = {13'b0, r_dst};
            2'd2: prdata = {19'b0, r_dblk};
            2'd3: prdata = {17'b0, r_scr};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= 19'd48000;
            r_dst  <= 19'd0;
            r_dblk <= 13'd512;
            r_scr  <= 15'd8192;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                2'd0: r_src  <= pwdata[18:0];
                2'd1: r_dst  <= pwdata[18:0];
                2'd2: r_dblk <= pwdata[12:0];
                2'd3: r_scr  <= pwdata[14:0];
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        mul_a = (r_state == ST_NEED) ? r_speed : r_base;
        unique case (r_state)
            ST_ADJMUL: mul_b = r_ratio;
            ST_NEED:   mul_b = {12'b0, r_samples};
            default:   mul_b = {12'b0, r_dblk};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        logic          flushed;
        logic [13:0]   v_ready, v_disc;
        logic          v_pri;
        logic [SW-1:0] v_s, v_readyf;
        logic [TW-1:0] keep;
        logic [SW:0]   diff;
        logic [SW-1:0] dmag, q_s;
        logic [TW-1:0] denom, emag;
        logic [29:0]   sum_sp;
        logic [PW:0]   need_raw;
        logic [19:0]   needed;

        n_state     = r_state;
        n_pending   = r_pending;
        n_priming   = r_priming;
        n_smooth    = r_smooth;
        n_restart   = r_restart;
        n_ready     = r_ready;
        n_disc      = r_disc;
        n_samples   = r_samples;
        n_base      = r_base;
        n_speed     = r_speed;
        n_target    = r_target;
        n_dneg      = r_dneg;
        n_neg       = r_neg;
        n_ratio     = r_ratio;
        n_res_act   = r_res_act;
        n_res_disc  = r_res_disc;
        n_res_read  = r_res_read;
        n_res_speed = r_res_speed;
        div_req     = '0;
        div_init    = '0;
        div_dvd     = '0;
        div_dsor    = '0;
        load_out    = 1'b0;
        o_ready     = 1'b0;

        flushed  = r_pending | r_restart;
        v_ready  = r_ready;
        v_disc   = '0;
        v_pri    = r_priming;
        v_s      = r_smooth;
        v_readyf = '0;
        keep     = '0;
        diff     = '0;
        dmag     = '0;
        q_s      = div_quot[SW-1:0];
        denom    = (r_target > TW'(1 << F)) ? r_target : TW'(1 << F);
        emag     = '0;
        sum_sp   = {1'b0, r_base} + {1'b0, div_quot[28:0]};
        need_raw = {1'b0, r_prod} + (PW+1)'(24'hFF_FFFF);
        needed   = 20'(need_raw[PW:24]) + 20'd8;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_restart = i_restart;
                    n_samples = i_block_samples;
                    n_ready   = ({3'b0, i_fifo_fill} > 17'(FIFO_DEPTH))
                              ? 14'(FIFO_DEPTH) : i_fifo_fill;
                    if (i_output_channels == '0 || r_dst == '0) begin
                        n_pending   = r_pending | i_restart;
                        n_res_act   = ACT_NO_DEVICE;
                        n_res_disc  = '0;
                        n_res_read  = '0;
                        n_res_speed = '0;
                        n_state     = ST_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.steps = STEP_W'(43);
                        div_dvd  = DW'({r_src, 24'b0}) << (DW - 43);
                        div_dsor = RW'(r_dst);
                        n_state  = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                if (div_fin) begin
                    n_base = (div_quot[DW-1:29] != '0) ? SPEED_MAX : div_quot[28:0];
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(21 + F);
                    div_dvd  = DW'({21'(r_src * 2'd3), F'(0)}) << (DW - 21 - F);
                    div_dsor = RW'(200);
                    n_state  = ST_TGT;
                end
            end
            ST_TGT: begin
                if (div_fin) begin
                    n_target = TW'(div_quot) + TW'(r_prod >> (24 - F));
                    n_state  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_pending = 1'b0;
                if (flushed) begin
                    v_disc  = r_ready;
                    v_ready = '0;
                    v_pri   = 1'b1;
                end
                v_readyf = SW'(v_ready) << F;
                if (v_pri && TW'(v_readyf) < r_target) begin
                    n_priming   = 1'b1;
                    n_res_act   = flushed ? ACT_FLUSHED : ACT_PRIMING;
                    n_res_disc  = v_disc;
                    n_res_read  = '0;
                    n_res_speed = '0;
                    n_state     = ST_DONE;
                end else begin
                    if (v_pri) begin
                        v_pri = 1'b0;
                        v_s   = v_readyf;
                    end
                    if ((TW+2)'(v_readyf) > {r_target, 2'b0}) begin
                        keep     = r_target >> F;
                        v_disc   = v_disc + (v_ready - keep[13:0]);
                        v_ready  = keep[13:0];
                        v_readyf = SW'(v_ready) << F;
                        v_s      = v_readyf;
                    end
                    diff = {1'b0, v_readyf} - {1'b0, v_s};
                    dmag = diff[SW] ? SW'(-diff) : diff[SW-1:0];
                    n_priming = v_pri;
                    n_smooth  = v_s;
                    n_ready   = v_ready;
                    n_disc    = v_disc;
                    n_dneg    = diff[SW];
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(SW);
                    div_dvd  = DW'(dmag) << (DW - SW);
                    div_dsor = RW'(20);
                    n_state  = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                if (div_fin) begin
                    if (r_dneg) begin
                        n_smooth = r_smooth - (q_s + SW'(div_rem != '0));
                    end else begin
                        n_smooth = r_smooth + q_s;
                    end
                    n_state = ST_RATIO;
                end
            end
            ST_RATIO: begin
                n_neg = TW'(r_smooth) < r_target;
                emag  = n_neg ? r_target - TW'(r_smooth) : TW'(r_smooth) - r_target;
                if (emag >= denom) begin
                    n_ratio = 25'h100_0000;
                    n_state = ST_ADJMUL;
                end else begin
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(24);
                    div_init = RW'(emag);
                    div_dsor = RW'(denom);
                    n_state  = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (div_fin) begin
                    n_ratio = div_quot[24:0];
                    n_state = ST_ADJMUL;
                end
            end
            ST_ADJMUL: n_state = ST_ADJSTART;
            ST_ADJSTART: begin
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(30);
                div_dvd  = DW'(r_prod[53:24]) << (DW - 30);
                div_dsor = RW'(250);
                n_state  = ST_ADJDIV;
            end
            ST_ADJDIV: begin
                if (div_fin) begin
                    if (r_neg) begin
                        n_speed = r_base - div_quot[28:0];
                    end else begin
                        n_speed = sum_sp[29] ? SPEED_MAX : sum_sp[28:0];
                    end
                    n_state = ST_NEED;
                end
            end
            ST_NEED: n_state = ST_FIN;
            ST_FIN: begin
                n_res_disc  = r_disc;
                n_res_speed = r_speed;
                n_res_read  = '0;
                priority if (needed > 20'(r_scr)) begin
                    n_res_act = ACT_SCRATCH;
                end else if (20'(r_ready) < needed) begin
                    n_priming = 1'b1;
                    n_res_act = ACT_UNDERRUN;
                end else begin
                    n_res_act  = ACT_PLAY;
                    n_res_read = needed[14:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= 1'b0;
            r_priming   <= 1'b1;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_priming <= n_priming;
            r_smooth  <= n_smooth;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_restart   <= n_restart;
        r_ready     <= n_ready;
        r_disc      <= n_disc;
        r_samples   <= n_samples;
        r_base      <= n_base;
        r_speed     <= n_speed;
        r_target    <= n_target;
        r_dneg      <= n_dneg;
        r_neg       <= n_neg;
        r_ratio     <= n_ratio;
        r_res_act   <= n_res_act;
        r_res_disc  <= n_res_disc;
        r_res_read  <= n_res_read;
        r_res_speed <= n_res_speed;
        if (load_out) begin
            r_o_act   <= r_res_act;
            r_o_disc  <= r_res_disc;
            r_o_read  <= r_res_read;
            r_o_speed <= r_res_speed;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_o_act;
    assign o_discard_count = r_o_disc;
    assign o_read_count    = r_o_read;
    assign o_speed         = r_o_speed;

endmodule

>>> src/ffrrc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ffrrc_div
    import ffrrc_pkg::*;
#(
    parameter int DW = 43,
    parameter int RW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [RW-1:0] i_init_rem,
    input  logic [DW-1:0] i_dividend,
    input  logic [RW-1:0] i_divisor,
    output logic          o_fin,
    output logic [DW-1:0] o_quot,
    output logic [RW-1:0] o_rem
);

    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_fin, n_fin;
    logic [RW-1:0]     r_rem, n_rem, r_dsor, n_dsor;
    logic [DW-1:0]     r_dvd, n_dvd, r_quot, n_quot;
    logic [RW-1:0]     trial;

    always_comb begin
        trial  = {r_rem[RW-2:0], r_dvd[DW-1]};
        n_cnt  = r_cnt;
        n_fin  = 1'b0;
        n_rem  = r_rem;
        n_dsor = r_dsor;
        n_dvd  = r_dvd;
        n_quot = r_quot;
        if (i_req.start) begin
            n_cnt  = i_req.steps;
            n_rem  = i_init_rem;
            n_dsor = i_divisor;
            n_dvd  = i_dividend;
            n_quot = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_fin = (r_cnt == STEP_W'(1));
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            if (trial >= r_dsor) begin
                n_rem  = trial - r_dsor;
                n_quot = {r_quot[DW-2:0], 1'b1};
            end else begin
                n_rem  = trial;
                n_quot = {r_quot[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fin <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fin <= n_fin;
        end
        r_rem  <= n_rem;
        r_dsor <= n_dsor;
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
    end

    assign o_fin  = r_fin;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> src/ffrrc_chk.sv
// port checker for the fifo fill resampling ratio control, with its bind
module ffrrc_chk
    import ffrrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_action,
    input logic [13:0] o_discard_count,
    input logic [14:0] o_read_count,
    input logic [28:0] o_speed
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action)
            && $stable(o_read_count) && $stable(o_speed))
        else $error("stalled result changed");

    a_read_only_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action != ACT_PLAY |-> o_read_count == '0)
        else $error("read count outside play");

    a_silent_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == ACT_NO_DEVICE || o_action == ACT_FLUSHED
            || o_action == ACT_PRIMING) |-> o_speed == '0)
        else $error("speed while silent");

    a_no_device: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_NO_DEVICE |-> o_discard_count == '0)
        else $error("discard without device");

endmodule

bind fifo_fill_resample_ratio_control ffrrc_chk u_ffrrc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_action        (o_action),
    .o_discard_count (o_discard_count),
    .o_read_count    (o_read_count),
    .o_speed         (o_speed)
);
